// ===== hw/rtl/kmp_pkg.sv =====
package kmp_pkg;

  localparam int MAX_LEN  = 1024;
  localparam int ADDR_W   = $clog2(MAX_LEN);
  localparam int POS_W    = ADDR_W + 1;
  localparam int CH_W     = 8;
  localparam int BORDER_W = 10;

  // Datapath commands from the controller
  typedef struct packed {
    logic load;    // take a new byte from the input port
    logic step;    // follow one failure link
    logic hit;     // byte matched: extend the border by one
    logic commit;  // write stores, update state, load the result register
  } kmp_cmd_t;

  // Datapath status toward the controller
  typedef struct packed {
    logic first;     // byte lands at position zero
    logic full;      // store already holds MAX_LEN bytes
    logic match;     // stored byte after current border equals the new byte
    logic j_zero;    // current border length is zero
    logic out_free;  // result register can take a new result this cycle
  } kmp_status_t;

endpackage

// ===== hw/rtl/kmp_datapath.sv =====
module kmp_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  kmp_pkg::kmp_cmd_t             cmd,
  output kmp_pkg::kmp_status_t          status,
  input  logic [kmp_pkg::CH_W-1:0]      ch,
  input  logic                          start_req,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [kmp_pkg::BORDER_W-1:0]  border_len,
  output logic                          overflow
);

  logic [kmp_pkg::CH_W-1:0]   text_mem [kmp_pkg::MAX_LEN];
  logic [kmp_pkg::ADDR_W-1:0] border_mem [kmp_pkg::MAX_LEN];

  logic [kmp_pkg::CH_W-1:0]   ch_reg;
  logic                       ovf_reg;
  logic [kmp_pkg::POS_W-1:0]  pos;
  logic [kmp_pkg::ADDR_W-1:0] last;
  logic [kmp_pkg::ADDR_W-1:0] j;
  logic [kmp_pkg::ADDR_W-1:0] j_next;
  logic [kmp_pkg::ADDR_W-1:0] link;
  logic [kmp_pkg::POS_W-1:0]  pos_eff;
  logic [kmp_pkg::ADDR_W-1:0] last_eff;
  logic [kmp_pkg::CH_W-1:0]   text_rd;
  logic [kmp_pkg::ADDR_W-1:0] border_rd;
  logic [kmp_pkg::ADDR_W-1:0] link_addr;
  logic [kmp_pkg::ADDR_W-1:0] wr_addr;

  assign pos_eff  = start_req ? '0 : pos;
  assign last_eff = start_req ? '0 : last;
  assign wr_addr  = pos[kmp_pkg::ADDR_W-1:0];

  // a link always shrinks; clamp anything else to zero
  assign link = (border_rd >= j) ? '0 : border_rd;

  always_comb begin
    j_next = j;
    if (cmd.load) begin
      if ((pos_eff == '0) || (pos_eff >= kmp_pkg::POS_W'(kmp_pkg::MAX_LEN))) begin
        j_next = '0;
      end else begin
        j_next = last_eff;
      end
    end else if (cmd.step) begin
      j_next = link;
    end else if (cmd.hit) begin
      j_next = j + kmp_pkg::ADDR_W'(1);
    end
  end

  // read data always belongs to the current j
  assign link_addr = j_next - kmp_pkg::ADDR_W'(1);

  always_ff @(posedge clk) begin
    text_rd   <= text_mem[j_next];
    border_rd <= border_mem[link_addr];
    if (cmd.commit && !ovf_reg) begin
      text_mem[wr_addr]   <= ch_reg;
      border_mem[wr_addr] <= j;
    end
  end

  always_ff @(posedge clk) begin
    j <= j_next;
    if (cmd.load) begin
      ch_reg  <= ch;
      ovf_reg <= (pos_eff >= kmp_pkg::POS_W'(kmp_pkg::MAX_LEN));
    end
    if (cmd.commit) begin
      border_len <= ovf_reg ? '0 : kmp_pkg::BORDER_W'(j);
      overflow   <= ovf_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      last         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        pos  <= pos_eff;
        last <= last_eff;
      end else if (cmd.commit && !ovf_reg) begin
        pos  <= pos + kmp_pkg::POS_W'(1);
        last <= j;
      end
      if (cmd.commit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign status.first    = (pos_eff == '0);
  assign status.full     = (pos_eff >= kmp_pkg::POS_W'(kmp_pkg::MAX_LEN));
  assign status.match    = (text_rd == ch_reg);
  assign status.j_zero   = (j == '0);
  assign status.out_free = !result_valid || !result_stall;

endmodule

// ===== hw/rtl/kmp_ctrl.sv =====
module kmp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  kmp_pkg::kmp_status_t  status,
  output kmp_pkg::kmp_cmd_t     cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WALK   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign item_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load = 1'b1;
          state_next = (status.first || status.full) ? S_FINISH : S_WALK;
        end
      end
      S_WALK: begin
        if (status.match) begin
          cmd.hit    = 1'b1;
          state_next = S_FINISH;
        end else if (status.j_zero) begin
          state_next = S_FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/kmp_prefix_function.sv =====
// Online KMP prefix function.
// Input channel (item_valid / item_stall): one byte ch per transfer, with
// start_req high on the first byte of a new string. Output channel
// (result_valid / result_stall): one result per input transfer, in order,
// carrying border_len (longest proper border of the prefix so far) and
// overflow (string longer than MAX_LEN; byte dropped, border_len zero).
// Timing: a byte is taken in the idle state, then the failure-link walk
// runs one link per cycle (text and border stores read in parallel at the
// current border length), then the commit step writes the stores and
// loads the result register. Links followed amortize to under one per
// byte over a string. The first byte of a string and an overflowed byte
// skip the walk and go straight to the commit step.
// item_stall is high while an item is in the walk or waiting to commit.
// When the receiver stalls, the result register holds its value and a new
// byte is still taken; its commit then waits for the register to free up.
// Reset clears the position and last border, so the first byte after
// reset starts a string. The stores are not cleared: the walk only reads
// entries already written for the current string.
module kmp_prefix_function (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [kmp_pkg::CH_W-1:0]      ch,
  input  logic                          start_req,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [kmp_pkg::BORDER_W-1:0]  border_len,
  output logic                          overflow
);

  kmp_pkg::kmp_cmd_t    cmd;
  kmp_pkg::kmp_status_t status;

  // sequencing: accept, walk links, commit
  kmp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // stores, border register and result register
  kmp_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .ch           (ch),
    .start_req    (start_req),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .border_len   (border_len),
    .overflow     (overflow)
  );

endmodule
